@@ sv/ggs_pkg.sv @@
// shared types and constants of the go-to-goal steering block
`default_nettype none
package ggs_pkg;

    localparam int POS_W   = 15;
    localparam int ANG_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 16;
    localparam int DIFF_W  = 16;
    localparam int SQ_W    = 32;
    localparam int XY_W    = 19;
    localparam int Z_W     = 17;
    localparam int ERR_W   = 18;
    localparam int PROD_W  = 32;
    localparam int FRAC_GAIN = 12;

    localparam int SQRT_STEPS = 16;
    localparam int TABLE_LEN  = 24;

    localparam logic [15:0]          DIST_MIN  = 16'd205;
    localparam logic [ERR_W-1:0]     ANGLE_MIN = 18'd1638;
    localparam logic signed [Z_W-1:0] HALF_PI  = 17'sd12868;

    localparam logic signed [15:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
        16'sd6434, 16'sd3798, 16'sd2007, 16'sd1019, 16'sd511, 16'sd256,
        16'sd128, 16'sd64, 16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2, 16'sd1,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd0, 16'sd0
    };

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_GOAL_X      = 2'd0,
        REG_GOAL_Y      = 2'd1,
        REG_GAIN        = 2'd2,
        REG_SPEED_LIMIT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]   goal_x;
        logic [POS_W-1:0]   goal_y;
        logic [GAIN_W-1:0]  gain;
        logic [SPEED_W-1:0] speed_limit;
    } cfg_t;

    typedef struct packed {
        logic [SQ_W-1:0]         rem;
        logic [SQ_W-1:0]         root;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
        logic signed [ANG_W-1:0] heading;
    } cell_data_t;

endpackage
`default_nettype wire

@@ sv/ggs_pose_if.sv @@
// pose request channel
`default_nettype none
interface ggs_pose_if;
    logic               valid;
    logic               ready;
    logic [14:0]        pos_x;
    logic [14:0]        pos_y;
    logic signed [15:0] heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface
`default_nettype wire

@@ sv/ggs_cmd_if.sv @@
// drive command request channel
`default_nettype none
interface ggs_cmd_if;
    logic        valid;
    logic        ready;
    logic [15:0] forward_speed;
    logic [15:0] turn_rate;

    modport source (output valid, output forward_speed, output turn_rate, input ready);
    modport sink (input valid, input forward_speed, input turn_rate, output ready);
endinterface
`default_nettype wire

@@ sv/ggs_regs.sv @@
// configuration register file with apb-style access
`default_nettype none
module ggs_regs
    import ggs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GOAL_X:      cfg_next.goal_x      = pwdata[POS_W-1:0];
                REG_GOAL_Y:      cfg_next.goal_y      = pwdata[POS_W-1:0];
                REG_GAIN:        cfg_next.gain        = pwdata[GAIN_W-1:0];
                REG_SPEED_LIMIT: cfg_next.speed_limit = pwdata[SPEED_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GOAL_X:      prdata = DATA_W'(cfg_reg.goal_x);
            REG_GOAL_Y:      prdata = DATA_W'(cfg_reg.goal_y);
            REG_GAIN:        prdata = DATA_W'(cfg_reg.gain);
            REG_SPEED_LIMIT: prdata = DATA_W'(cfg_reg.speed_limit);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_x      <= 15'd2048;
            cfg_reg.goal_y      <= 15'd2048;
            cfg_reg.gain        <= 16'd4096;
            cfg_reg.speed_limit <= 16'd2048;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/ggs_front.sv @@
// offsets to goal, squares, and seeding of the cell chain
`default_nettype none
module ggs_front
    import ggs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ggs_pose_if.sink  pose,
    input  wire cfg_t cfg,
    output cell_data_t data_out,
    output logic      valid_out,
    input  wire logic take_down
);

    logic v0_reg, v1_reg, v2_reg;
    logic take0, take1, take2;

    logic signed [DIFF_W-1:0]  dx0_reg, dy0_reg;
    logic signed [ANG_W-1:0]   hd0_reg;
    logic signed [DIFF_W-1:0]  dx1_reg, dy1_reg;
    logic signed [ANG_W-1:0]   hd1_reg;
    logic [SQ_W-1:0]           dx2_reg, dy2_reg;
    cell_data_t                seed_reg;
    cell_data_t                seed_next;

    logic signed [DIFF_W-1:0]  dx_next, dy_next;
    logic signed [SQ_W-1:0]    sqx, sqy;

    assign take2 = !v2_reg || take_down;
    assign take1 = !v1_reg || take2;
    assign take0 = !v0_reg || take1;
    assign pose.ready = take0;

    assign valid_out = v2_reg;
    assign data_out  = seed_reg;

    assign dx_next = $signed({1'b0, cfg.goal_x}) - $signed({1'b0, pose.pos_x});
    assign dy_next = $signed({1'b0, cfg.goal_y}) - $signed({1'b0, pose.pos_y});
    assign sqx = dx0_reg * dx0_reg;
    assign sqy = dy0_reg * dy0_reg;

    always_comb
    begin
        seed_next.rem     = dx2_reg + dy2_reg;
        seed_next.root    = '0;
        seed_next.heading = hd1_reg;
        if (dx1_reg < 0)
        begin
            if (dy1_reg >= 0)
            begin
                seed_next.x = XY_W'(dy1_reg);
                seed_next.y = -XY_W'(dx1_reg);
                seed_next.z = HALF_PI;
            end
            else
            begin
                seed_next.x = -XY_W'(dy1_reg);
                seed_next.y = XY_W'(dx1_reg);
                seed_next.z = -HALF_PI;
            end
        end
        else
        begin
            seed_next.x = XY_W'(dx1_reg);
            seed_next.y = XY_W'(dy1_reg);
            seed_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (take0)
                v0_reg <= pose.valid;
            if (take1)
                v1_reg <= v0_reg;
            if (take2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take0)
        begin
            dx0_reg <= dx_next;
            dy0_reg <= dy_next;
            hd0_reg <= pose.heading;
        end
        if (take1)
        begin
            dx1_reg <= dx0_reg;
            dy1_reg <= dy0_reg;
            hd1_reg <= hd0_reg;
            dx2_reg <= sqx;
            dy2_reg <= sqy;
        end
        if (take2)
            seed_reg <= seed_next;
    end

endmodule
`default_nettype wire

@@ sv/ggs_cell.sv @@
// one cell: a square-root digit step and/or a cordic vectoring step, each enabled by its step index
`default_nettype none
module ggs_cell
    import ggs_pkg::*;
#(
    parameter int STEP          = 0,
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_data_t data_in,
    input  wire logic       valid_in,
    output logic            take_up,
    output cell_data_t      data_out,
    output logic            valid_out,
    input  wire logic       take_down
);

    localparam bit DO_ROT  = STEP < CORDIC_STAGES;
    localparam bit DO_SQRT = STEP < SQRT_STEPS;
    localparam int BIT_POS = DO_SQRT ? (2 * (SQRT_STEPS - 1) - 2 * STEP) : 0;
    localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << BIT_POS;

    logic       valid_reg;
    cell_data_t data_reg;
    cell_data_t data_next;

    logic [SQ_W-1:0]        trial;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  ang;

    assign take_up   = !valid_reg || take_down;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    assign trial = data_in.root + BIT_VAL;
    assign xs    = data_in.x >>> STEP;
    assign ys    = data_in.y >>> STEP;
    assign ang   = Z_W'(ATAN_TABLE[STEP]);

    always_comb
    begin
        data_next = data_in;
        if (DO_SQRT)
        begin
            if (data_in.rem >= trial)
            begin
                data_next.rem  = data_in.rem - trial;
                data_next.root = (data_in.root >> 1) + BIT_VAL;
            end
            else
            begin
                data_next.root = data_in.root >> 1;
            end
        end
        if (DO_ROT)
        begin
            if (data_in.y >= 0)
            begin
                data_next.x = data_in.x + ys;
                data_next.y = data_in.y - xs;
                data_next.z = data_in.z + ang;
            end
            else
            begin
                data_next.x = data_in.x - ys;
                data_next.y = data_in.y + xs;
                data_next.z = data_in.z - ang;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take_up)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (take_up)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

@@ sv/ggs_back.sv @@
// heading error, steering decision, speed product and output register
`default_nettype none
module ggs_back
    import ggs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire cell_data_t data_in,
    input  wire logic       valid_in,
    output logic            take_up,
    ggs_cmd_if.source       cmd
);

    logic vp_reg, vo_reg;
    logic take_o;

    logic                   far_reg, turn_reg;
    logic [15:0]            mag_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SPEED_W-1:0]     fs_reg, tr_reg;

    logic [15:0]             distance;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        mag;
    logic [15:0]             mag_sat;
    logic [PROD_W-FRAC_GAIN-1:0] spd_raw;
    logic [SPEED_W-1:0]      spd;
    logic [SPEED_W-1:0]      fs_next, tr_next;

    assign take_o  = !vo_reg || cmd.ready;
    assign take_up = !vp_reg || take_o;

    assign distance = data_in.root[15:0];
    assign err      = ERR_W'(data_in.z) - ERR_W'(data_in.heading);
    assign mag      = (err < 0) ? ERR_W'(-err) : ERR_W'(err);
    assign mag_sat  = (mag > ERR_W'(16'hFFFF)) ? 16'hFFFF : mag[15:0];

    assign spd_raw = prod_reg[PROD_W-1:FRAC_GAIN];
    assign spd     = (spd_raw > (PROD_W-FRAC_GAIN)'(cfg.speed_limit)) ? cfg.speed_limit
                                                                      : spd_raw[15:0];
    assign fs_next = (far_reg && !turn_reg) ? spd : '0;
    assign tr_next = (far_reg && turn_reg) ? mag_reg : '0;

    assign cmd.valid         = vo_reg;
    assign cmd.forward_speed = fs_reg;
    assign cmd.turn_rate     = tr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (take_up)
                vp_reg <= valid_in;
            if (take_o)
                vo_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_up)
        begin
            far_reg  <= distance > DIST_MIN;
            turn_reg <= mag > ANGLE_MIN;
            mag_reg  <= mag_sat;
            prod_reg <= cfg.gain * distance;
        end
        if (take_o)
        begin
            fs_reg <= fs_next;
            tr_reg <= tr_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/go_to_goal_steering_top.sv @@
// go-to-goal steering controller, top level
// pose to command: front registers, cells (CORDIC_STAGES or 16, whichever is more), back registers
// throughput: one pose per cycle unless the output stalls; every stage holds one request
// and moves on when the next stage is free, so bubbles close up while the output is stalled
// reset: asynchronous active low, empties the pipeline and loads goal 1.0, 1.0,
// gain 1.0 and speed limit 1.0
`default_nettype none
module go_to_goal_steering_top
    import ggs_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    ggs_pose_if.sink               pose,
    ggs_cmd_if.source              cmd,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int NUM_CELLS = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

    cfg_t       cfg;
    cell_data_t data  [0:NUM_CELLS];
    logic       valid [0:NUM_CELLS];
    logic       take  [0:NUM_CELLS];

    ggs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ggs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose      (pose),
        .cfg       (cfg),
        .data_out  (data[0]),
        .valid_out (valid[0]),
        .take_down (take[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        ggs_cell #(
            .STEP          (k),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .data_in   (data[k]),
            .valid_in  (valid[k]),
            .take_up   (take[k]),
            .data_out  (data[k+1]),
            .valid_out (valid[k+1]),
            .take_down (take[k+1])
        );
    end

    ggs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .data_in  (data[NUM_CELLS]),
        .valid_in (valid[NUM_CELLS]),
        .take_up  (take[NUM_CELLS]),
        .cmd      (cmd)
    );

endmodule
`default_nettype wire

@@ sim/go_to_goal_steering_top_tb.sv @@
`timescale 1ns / 1ps
// testbench for the go-to-goal steering controller: directed and random poses checked against a predictor
module go_to_goal_steering_top_tb;
    import ggs_pkg::*;

    localparam int     CORDIC_N     = 16;
    localparam int     SETTLE       = 30;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     PHASE_POSES  = 75;
    localparam longint REACH_DIST   = 205;
    localparam longint AIM_TOL      = 1638;
    localparam longint QUARTER_TURN = 12868;
    localparam longint ARCTAN_Q13 [24] = '{
        6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } flow_t;

    typedef struct {
        logic [15:0] speed;
        logic [15:0] turn;
    } drive_cmd_t;

    class steering_scoreboard;
        cfg_t       cfg;
        drive_cmd_t pending[$];
        int         errors;

        function new();
            cfg.goal_x      = 15'd2048;
            cfg.goal_y      = 15'd2048;
            cfg.gain        = 16'd4096;
            cfg.speed_limit = 16'd2048;
            errors          = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_GOAL_X:      cfg.goal_x      = data[14:0];
                REG_GOAL_Y:      cfg.goal_y      = data[14:0];
                REG_GAIN:        cfg.gain        = data[15:0];
                REG_SPEED_LIMIT: cfg.speed_limit = data[15:0];
                default:         ;
            endcase
        endfunction

        function logic [31:0] reg_value(reg_idx_t idx);
            case (idx)
                REG_GOAL_X:      return 32'(cfg.goal_x);
                REG_GOAL_Y:      return 32'(cfg.goal_y);
                REG_GAIN:        return 32'(cfg.gain);
                default:         return 32'(cfg.speed_limit);
            endcase
        endfunction

        function longint root_floor(longint unsigned n);
            longint unsigned rem;
            longint unsigned root;
            longint unsigned b;
            rem  = n;
            root = 0;
            b    = 64'd1 << 62;
            while (b > rem)
                b >>= 2;
            while (b != 0)
            begin
                if (rem >= root + b)
                begin
                    rem  -= root + b;
                    root  = (root >> 1) + b;
                end
                else
                begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return longint'(root);
        endfunction

        // vectoring cordic, pre-rotated into the right half plane
        function longint heading_of(longint dx, longint dy);
            longint x;
            longint y;
            longint z;
            longint t;
            longint xs;
            longint ys;
            x = dx;
            y = dy;
            z = 0;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x; x = y; y = -t; z = QUARTER_TURN;
                end
                else
                begin
                    t = x; x = -y; y = t; z = -QUARTER_TURN;
                end
            end
            for (int i = 0; i < CORDIC_N; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys; y -= xs; z += ARCTAN_Q13[i];
                end
                else
                begin
                    x -= ys; y += xs; z -= ARCTAN_Q13[i];
                end
            end
            return z;
        endfunction

        function longint bearing_from(logic [14:0] px, logic [14:0] py);
            return heading_of(longint'(cfg.goal_x) - longint'(px),
                              longint'(cfg.goal_y) - longint'(py));
        endfunction

        function drive_cmd_t steer(logic [14:0] px, logic [14:0] py, logic signed [15:0] hd);
            drive_cmd_t c;
            longint     dx;
            longint     dy;
            longint     d;
            longint     err;
            longint     mag;
            longint     spd;
            dx      = longint'(cfg.goal_x) - longint'(px);
            dy      = longint'(cfg.goal_y) - longint'(py);
            d       = root_floor(longint'(dx * dx + dy * dy));
            c.speed = '0;
            c.turn  = '0;
            if (d > REACH_DIST)
            begin
                err = heading_of(dx, dy) - longint'(hd);
                mag = (err < 0) ? -err : err;
                if (mag > AIM_TOL)
                begin
                    c.turn = (mag > 65535) ? 16'hFFFF : mag[15:0];
                end
                else
                begin
                    spd = (longint'(cfg.gain) * d) >> 12;
                    if (spd > longint'(cfg.speed_limit))
                        spd = longint'(cfg.speed_limit);
                    c.speed = spd[15:0];
                end
            end
            return c;
        endfunction

        function void note_pose(logic [14:0] px, logic [14:0] py, logic signed [15:0] hd);
            pending.push_back(steer(px, py, hd));
        endfunction

        function void check_cmd(logic [15:0] speed, logic [15:0] turn);
            drive_cmd_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: drive command with no pose pending, speed %0d turn %0d",
                         $time, speed, turn);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (speed !== want.speed)
            begin
                $display("%0t: forward_speed expected %0d actual %0d", $time, want.speed, speed);
                errors++;
            end
            if (turn !== want.turn)
            begin
                $display("%0t: turn_rate expected %0d actual %0d", $time, want.turn, turn);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ggs_pose_if pose_ch();
    ggs_cmd_if  cmd_ch();

    go_to_goal_steering_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pose    (pose_ch),
        .cmd     (cmd_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    steering_scoreboard sb = new();
    flow_t              flow = FLOW_FREE;
    int unsigned        cycles = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            sb.check_cmd(cmd_ch.forward_speed, cmd_ch.turn_rate);
        if (flow == FLOW_SINK_STALL)
            cmd_ch.ready <= ($urandom_range(99) >= 47);
        else if (flow == FLOW_BOTH)
            cmd_ch.ready <= ($urandom_range(99) >= 19);
        else
            cmd_ch.ready <= 1'b1;
    end

    task automatic send_pose(input logic [14:0] px, input logic [14:0] py,
                             input logic signed [15:0] hd);
        int gap;
        int pct;
        gap = 0;
        pct = (flow == FLOW_SRC_IDLE) ? 47 : (flow == FLOW_BOTH) ? 19 : 0;
        while (int'($urandom_range(99)) < pct)
            gap++;
        if (gap > 0)
        begin
            pose_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pose_ch.valid   <= 1'b1;
        pose_ch.pos_x   <= px;
        pose_ch.pos_y   <= py;
        pose_ch.heading <= hd;
        do @(posedge clk); while (!pose_ch.ready);
        sb.note_pose(px, py, hd);
    endtask

    function automatic logic [14:0] near(logic [14:0] centre);
        int v;
        v = int'(centre) + int'($urandom_range(800)) - 400;
        if (v < 0)
            v = 0;
        if (v > 32767)
            v = 32767;
        return v[14:0];
    endfunction

    // mostly poses aimed near the bearing or close to the goal, the rest noise
    task automatic random_pose();
        int                 kind;
        logic [14:0]        px;
        logic [14:0]        py;
        logic signed [15:0] hd;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            px = 15'($urandom);
            py = 15'($urandom);
            hd = 16'(sb.bearing_from(px, py) + longint'($urandom_range(4000)) - 2000);
        end
        else if (kind < 55)
        begin
            px = near(sb.cfg.goal_x);
            py = near(sb.cfg.goal_y);
            if ($urandom_range(1) == 1)
                hd = 16'(sb.bearing_from(px, py) + longint'($urandom_range(4000)) - 2000);
            else
                hd = 16'($urandom);
        end
        else if (kind < 90)
        begin
            px = 15'($urandom);
            py = 15'($urandom);
            hd = 16'($urandom);
        end
        else
        begin
            px = 15'($urandom_range(24575));
            py = 15'($urandom_range(24575));
            hd = 16'(int'($urandom_range(51472)) - 25736);
        end
        send_pose(px, py, hd);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic reg_check(input reg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== sb.reg_value(idx))
        begin
            $display("%0t: register %s expected %0d actual %0d", $time, idx.name(),
                     sb.reg_value(idx), prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] gx, input logic [31:0] gy,
                                  input logic [31:0] g, input logic [31:0] lim);
        reg_write(REG_GOAL_X, gx);
        reg_write(REG_GOAL_Y, gy);
        reg_write(REG_GAIN, g);
        reg_write(REG_SPEED_LIMIT, lim);
        reg_check(REG_GOAL_X);
        reg_check(REG_GOAL_Y);
        reg_check(REG_GAIN);
        reg_check(REG_SPEED_LIMIT);
    endtask

    task automatic drain();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int ph;
        pose_ch.valid   = 1'b0;
        pose_ch.pos_x   = '0;
        pose_ch.pos_y   = '0;
        pose_ch.heading = '0;
        cmd_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_check(REG_GOAL_X);
        reg_check(REG_GOAL_Y);
        reg_check(REG_GAIN);
        reg_check(REG_SPEED_LIMIT);

        // goal at 1.0, 1.0 after reset
        send_pose(15'd2048, 15'd2048, 16'sd0);
        send_pose(15'd1843, 15'd2048, 16'sd0);
        send_pose(15'd1842, 15'd2048, 16'sd0);
        send_pose(15'd2048, 15'd2254, 16'sd0);
        send_pose(15'd0, 15'd2048, 16'sd1638);
        send_pose(15'd0, 15'd2048, 16'sd1639);
        send_pose(15'd0, 15'd2048, -16'sd1638);
        send_pose(15'd0, 15'd2048, -16'sd1639);
        send_pose(15'd0, 15'd0, 16'(sb.bearing_from(15'd0, 15'd0)));
        send_pose(15'd24575, 15'd24575, 16'sd25736);
        send_pose(15'd32767, 15'd32767, -16'sd32768);
        send_pose(15'd32767, 15'd0, 16'sd32767);
        send_pose(15'd4096, 15'd2048, 16'(sb.bearing_from(15'd4096, 15'd2048)));
        send_pose(15'd4096, 15'd2048, -16'sd25736);
        send_pose(15'd4096, 15'd4096, 16'(sb.bearing_from(15'd4096, 15'd4096)));
        send_pose(15'd4096, 15'd0, 16'(sb.bearing_from(15'd4096, 15'd0)));
        send_pose(15'd2048, 15'd0, 16'(sb.bearing_from(15'd2048, 15'd0)));
        send_pose(15'd1000, 15'd3000, -16'sd32768);
        send_pose(15'd0, 15'd32767, 16'sd32767);
        send_pose(15'd24575, 15'd0, -16'sd25736);
        pose_ch.valid <= 1'b0;

        for (ph = 1; ph <= 8; ph++)
        begin
            drain();
            case (ph)
                1:       apply_settings(32'd0, 32'd0, 32'd65535, 32'd65535);
                2:       apply_settings(32'd32767, 32'd32767, 32'd0, 32'd0);
                3:       apply_settings(32'd24575, 32'd12288, 32'd8192, 32'd4096);
                8:       apply_settings(32'd2048, 32'd2048, 32'd4096, 32'd2048);
                default: apply_settings($urandom, $urandom, $urandom, $urandom);
            endcase
            flow = flow_t'(ph % 4);
            repeat (PHASE_POSES) random_pose();
            pose_ch.valid <= 1'b0;
        end

        drain();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
